// ===== rtl/mtr_pkg.sv =====
// Package for the ranged Mersenne Twister generator.
// Holds state encodings, command and status structs, and twister constants.
`timescale 1ns / 1ps
`default_nettype none
package mtr_pkg;
    localparam int unsigned WORDS   = 624;
    localparam int unsigned OFFSET  = 397;
    localparam int unsigned AW      = 10;
    localparam logic [31:0] MATRIX  = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C = 32'hEFC60000;
    localparam logic [31:0] SEED_MULT = 32'd69069;
    localparam logic [31:0] UPPER   = 32'h80000000;
    localparam logic [31:0] LOWER   = 32'h7FFFFFFF;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEED, ST_GEN_RD0, ST_GEN_RD1, ST_GEN_RD2, ST_GEN_WR,
        ST_FETCH, ST_FETCH_WAIT, ST_DIV, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;     // capture request fields
        logic reseed;       // capture seed from request
        logic seed_init;    // start fill: bump seed, set x
        logic seed_step;    // write one fill word
        logic gen_init;     // clear index counter
        logic gen_rd0;      // read cur word
        logic gen_rd1;      // latch cur, read nxt word
        logic gen_rd2;      // latch nxt, read far word
        logic gen_wr;       // write regenerated word
        logic fetch;        // issue read of next output word
        logic div_init;     // latch word, start modulo
        logic div_step;     // one restoring step
        logic out_load;     // fill output register
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic cmd;
        logic pending;
        logic empty;
        logic last;         // fill or regen index at final word
        logic div_done;
    } stat_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mtr_ctrl.sv =====
// Controller for the ranged twister: sequences fill, regen, fetch and modulo.
// Depends on mtr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtr_ctrl import mtr_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire logic  m_valid,
    input  wire logic  m_ready,
    input  wire stat_t st,
    output ctrl_t      ctl
);
    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // sequence the request
    always_comb begin
        state_next = state_reg;
        ctl = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load_req = 1'b1;
                    if (st.cmd == CMD_RESEED) begin
                        ctl.reseed = 1'b1;
                    end else if (st.pending) begin
                        ctl.seed_init = 1'b1;
                        state_next = ST_SEED;
                    end else if (st.empty) begin
                        ctl.gen_init = 1'b1;
                        state_next = ST_GEN_RD0;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SEED: begin
                ctl.seed_step = 1'b1;
                if (st.last) begin
                    ctl.gen_init = 1'b1;
                    state_next = ST_GEN_RD0;
                end
            end
            ST_GEN_RD0: begin
                ctl.gen_rd0 = 1'b1;
                state_next = ST_GEN_RD1;
            end
            ST_GEN_RD1: begin
                ctl.gen_rd1 = 1'b1;
                state_next = ST_GEN_RD2;
            end
            ST_GEN_RD2: begin
                ctl.gen_rd2 = 1'b1;
                state_next = ST_GEN_WR;
            end
            ST_GEN_WR: begin
                ctl.gen_wr = 1'b1;
                state_next = st.last ? ST_FETCH : ST_GEN_RD0;
            end
            ST_FETCH: begin
                ctl.fetch = 1'b1;
                state_next = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT: begin
                ctl.div_init = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (st.div_done) state_next = ST_OUT;
                else             ctl.div_step = 1'b1;
            end
            ST_OUT: begin
                if (!m_valid || m_ready) begin
                    ctl.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    ap_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    ap_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.seed_step, ctl.gen_rd0, ctl.gen_rd1, ctl.gen_rd2, ctl.gen_wr,
                  ctl.fetch, ctl.div_step})) else $error("overlapping commands");
    ap_div_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> (state_reg == ST_FETCH_WAIT))
        else $error("fetch not followed by wait");
endmodule
`default_nettype wire

// ===== rtl/mtr_dp.sv =====
// Datapath for the ranged twister: word store, seed fill, regen, temper, modulo.
// Depends on mtr_pkg; driven by mtr_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module mtr_dp import mtr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_cmd,
    input  wire logic [31:0] s_seed_value,
    input  wire logic signed [31:0] s_range_low,
    input  wire logic signed [31:0] s_range_high,
    input  wire ctrl_t       ctl,
    output stat_t            st,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_raw_value,
    output logic signed [31:0] m_ranged_value,
    output logic             m_range_error
);
    logic [31:0] mem [WORDS];
    logic [31:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;

    logic [31:0] fallback_reg, seed_reg, x_reg;
    logic        pending_reg;
    logic [AW-1:0] left_reg, rp_reg, idx_reg;
    logic [31:0] cur_reg, nxt_reg;
    logic [31:0] lo_reg, hi_reg;
    logic [32:0] span_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        err_reg;
    logic [31:0] raw_reg;

    logic [AW-1:0] idx_p1, idx_far;
    logic [32:0] sub;
    logic [33:0] span_w;
    logic [31:0] y, nw;

    assign idx_p1  = (idx_reg == AW'(WORDS - 1)) ? '0 : idx_reg + 1'b1;
    assign idx_far = (idx_reg >= AW'(WORDS - OFFSET)) ? idx_reg - AW'(WORDS - OFFSET)
                                                     : idx_reg + AW'(OFFSET);
    assign span_w = {{2{hi_reg[31]}}, hi_reg} - {{2{lo_reg[31]}}, lo_reg} + 34'd1;
    assign y  = (cur_reg & UPPER) | (nxt_reg & LOWER);
    assign nw = rd_data_reg ^ (y >> 1) ^ (nxt_reg[0] ? MATRIX : 32'd0);
    assign sub = {rem_reg, quo_reg[31]} - span_reg;

    // pick the read address: cur, then nxt, then far
    always_comb begin
        rd_addr = rp_reg;
        if (ctl.gen_rd0)      rd_addr = idx_reg;
        else if (ctl.gen_rd1) rd_addr = idx_p1;
        else if (ctl.gen_rd2) rd_addr = idx_far;
    end
    // pick the write port
    always_comb begin
        wr_en = ctl.seed_step | ctl.gen_wr;
        wr_addr = idx_reg;
        wr_data = ctl.seed_step ? x_reg : nw;
    end

    // store words; registered read
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign st.cmd      = s_cmd;
    assign st.pending  = pending_reg;
    assign st.empty    = (left_reg == '0);
    assign st.last     = (idx_reg == AW'(WORDS - 1));
    assign st.div_done = (cnt_reg == 6'd32);

    // control and payload state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fallback_reg <= '0;
            seed_reg     <= '0;
            pending_reg  <= 1'b1;
            left_reg     <= '0;
            rp_reg       <= '0;
            m_valid      <= 1'b0;
        end else begin
            if (cfg_we) fallback_reg <= cfg_wdata;
            if (ctl.reseed) begin
                seed_reg    <= (s_seed_value != '0) ? s_seed_value : fallback_reg;
                pending_reg <= 1'b1;
            end
            if (ctl.seed_init) begin
                seed_reg    <= seed_reg + 32'd1;
                pending_reg <= 1'b0;
            end
            if (ctl.gen_wr && st.last) begin
                rp_reg   <= '0;
                left_reg <= AW'(WORDS);
            end
            if (ctl.fetch) begin
                rp_reg   <= (rp_reg == AW'(WORDS - 1)) ? '0 : rp_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (ctl.out_load) m_valid <= 1'b1;
        end
    end

    // fill, regen, modulo datapath
    always_ff @(posedge aclk) begin
        if (ctl.load_req) begin
            lo_reg <= s_range_low;
            hi_reg <= s_range_high;
        end
        if (ctl.seed_init) begin
            x_reg   <= (seed_reg + 32'd1) | 32'd1;
            idx_reg <= '0;
        end
        if (ctl.seed_step) begin
            x_reg   <= x_reg * SEED_MULT;
            idx_reg <= idx_p1;
        end
        if (ctl.gen_init) idx_reg <= '0;
        // cur arrives in rd1, nxt in rd2, far on the write cycle
        if (ctl.gen_rd1) cur_reg <= rd_data_reg;
        if (ctl.gen_rd2) nxt_reg <= rd_data_reg;
        if (ctl.gen_wr) idx_reg <= idx_p1;
        if (ctl.div_init) begin
            raw_reg  <= temper(rd_data_reg);
            quo_reg  <= temper(rd_data_reg);
            rem_reg  <= '0;
            cnt_reg  <= '0;
            err_reg  <= span_w[33] | (span_w[32:0] == '0);
            span_reg <= span_w[32:0];
        end
        if (ctl.div_step) begin
            cnt_reg <= cnt_reg + 6'd1;
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (!sub[32]) rem_reg <= sub[31:0];
            else          rem_reg <= {rem_reg[30:0], quo_reg[31]};
        end
        if (ctl.out_load) begin
            m_raw_value    <= raw_reg;
            m_range_error  <= err_reg;
            m_ranged_value <= err_reg ? lo_reg : rem_reg + lo_reg;
        end
    end

    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_raw_value)) else $error("output changed");
    ap_rp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rp_reg < AW'(WORDS)) else $error("pointer out of range");
    ap_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= AW'(WORDS)) else $error("count out of range");
endmodule
`default_nettype wire

// ===== rtl/mersenne_twister_ranged_rng.sv =====
// Ranged MT19937 generator top level: controller plus datapath.
// Draw: fetch, modulo, output; the next request waits until the result is loaded.
// First draw after seeding adds a 624-word fill and a regen pass; every 624th draw
// adds a regen pass (read cur, nxt, far, then write each word). Reseed: no result.
// The 32-step restoring modulo sets the draw rate.
// Reset (aresetn low, synchronous): fallback and current seed 0, seeding pending.
// Depends on mtr_pkg, mtr_ctrl and mtr_dp.
`timescale 1ns / 1ps
`default_nettype none
module mersenne_twister_ranged_rng import mtr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [31:0] s_seed_value,
    input  wire logic signed [31:0] s_range_low,
    input  wire logic signed [31:0] s_range_high,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_raw_value,
    output logic signed [31:0] m_ranged_value,
    output logic             m_range_error
);
    ctrl_t ctl;
    stat_t st;

    mtr_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .st, .ctl
    );
    mtr_dp u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .s_cmd, .s_seed_value, .s_range_low,
        .s_range_high, .ctl, .st, .m_valid, .m_ready, .m_raw_value,
        .m_ranged_value, .m_range_error
    );
endmodule
`default_nettype wire
